### src/t3t2_pkg.sv
// Shared types and constants of the T3 to T2 gated record converter.
`default_nettype none

package t3t2_pkg;

    // Field and register widths.
    localparam int SYNC_W        = 10;
    localparam int BIN_W         = 15;
    localparam int CHAN_W        = 6;
    localparam int TAG_W         = 25;
    localparam int OFF_W         = 32;
    localparam int WRAPS_W       = OFF_W - TAG_W;
    localparam int SYNC_SCALE_W  = 48;
    localparam int SYNC_LO_W     = 32;
    localparam int SYNC_HI_W     = SYNC_SCALE_W - SYNC_LO_W;
    localparam int DELAY_SCALE_W = 32;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 48;

    // Defaults for the top-level parameters.
    localparam int DEF_FRAC_BITS   = 16;
    localparam int DEF_QUEUE_DEPTH = 4;

    // Each count in a T3 overflow record stands for 2^T3_WRAP_BITS sync periods.
    localparam int T3_WRAP_BITS = 10;

    localparam logic [CHAN_W-1:0] OVF_CHAN = 6'h3F;

    // Register reset values.
    localparam logic [SYNC_SCALE_W-1:0]  SYNC_SCALE_RST  = 48'd65536;
    localparam logic [DELAY_SCALE_W-1:0] DELAY_SCALE_RST = 32'd65536;
    localparam logic [BIN_W-1:0]         GATE_LOW_RST    = 15'd0;
    localparam logic [BIN_W-1:0]         GATE_HIGH_RST   = 15'd32767;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SYNC_SCALE  = 2'd0,
        CFG_DELAY_SCALE = 2'd1,
        CFG_GATE_LOW    = 2'd2,
        CFG_GATE_HIGH   = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  we;
        t_cfg_idx              idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    // A gated photon waiting for its time to be worked out.
    typedef struct packed {
        logic [OFF_W-1:0]  stamp;
        logic [BIN_W-1:0]  delay;
        logic [CHAN_W-1:0] chan;
    } t_job;

endpackage

`default_nettype wire

### src/t3t2_front.sv
// Front end: accepts T3 records, tracks the input wrap offset and applies the delay gate.
`default_nettype none

module t3t2_front (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t3t2_pkg::t_cfg_wr       i_cfg,
    input  wire logic                    i_valid,
    input  wire logic [t3t2_pkg::SYNC_W-1:0] i_sync_count,
    input  wire logic [t3t2_pkg::BIN_W-1:0]  i_delay_bin,
    input  wire logic [t3t2_pkg::CHAN_W-1:0] i_chan,
    input  wire logic                    i_is_special,
    input  wire logic                    i_full,
    output logic                         o_push,
    output t3t2_pkg::t_job               o_job
);
    import t3t2_pkg::*;

    logic [OFF_W-1:0] r_in_off;
    logic [BIN_W-1:0] r_gate_low;
    logic [BIN_W-1:0] r_gate_high;
    logic             w_accept;
    logic             w_in_gate;
    logic             w_is_ovf;

    assign w_accept  = i_valid && !i_full;
    assign w_in_gate = (i_delay_bin >= r_gate_low) && (i_delay_bin <= r_gate_high);
    assign w_is_ovf  = i_is_special && (i_chan == OVF_CHAN);

    assign o_push      = w_accept && !i_is_special && w_in_gate;
    assign o_job.stamp = r_in_off + OFF_W'(i_sync_count);
    assign o_job.delay = i_delay_bin;
    assign o_job.chan  = i_chan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_off    <= '0;
            r_gate_low  <= GATE_LOW_RST;
            r_gate_high <= GATE_HIGH_RST;
        end else begin
            if (w_accept && w_is_ovf) begin
                r_in_off <= r_in_off + OFF_W'({i_sync_count, T3_WRAP_BITS'(0)});
            end
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_GATE_LOW:  r_gate_low  <= i_cfg.data[BIN_W-1:0];
                    CFG_GATE_HIGH: r_gate_high <= i_cfg.data[BIN_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### src/t3t2_queue.sv
// Short queue of gated photons between the front end and the arithmetic back end.
`default_nettype none

module t3t2_queue #(
    parameter int DEPTH = t3t2_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire t3t2_pkg::t_job i_job,
    input  wire logic           i_pop,
    output logic                o_full,
    output logic                o_empty,
    output t3t2_pkg::t_job      o_head
);
    import t3t2_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### src/t3t2_back.sv
// Back end: scales the photon time, tracks the output wrap offset and emits T2 records.
`default_nettype none

module t3t2_back #(
    parameter int FRAC_BITS = t3t2_pkg::DEF_FRAC_BITS
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire t3t2_pkg::t_cfg_wr          i_cfg,
    input  wire logic                       i_empty,
    input  wire t3t2_pkg::t_job             i_head,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic                            o_out_special,
    output logic [t3t2_pkg::CHAN_W-1:0]     o_out_chan,
    output logic [t3t2_pkg::TAG_W-1:0]      o_time_tag,
    output logic                            o_last_of_run
);
    import t3t2_pkg::*;

    // Only the bits up to the top of the 32-bit time field are ever needed.
    localparam int SUM_W  = FRAC_BITS + OFF_W;
    localparam int PLO_W  = OFF_W + SYNC_LO_W;
    localparam int PHI_W  = OFF_W + SYNC_HI_W;
    localparam int PD_W   = BIN_W + DELAY_SCALE_W;

    logic [SYNC_SCALE_W-1:0]  r_sync_scale;
    logic [DELAY_SCALE_W-1:0] r_delay_scale;

    // Stage 1: partial products.
    logic                 r_s1_valid;
    logic [PLO_W-1:0]     r_s1_p0;
    logic [FRAC_BITS-1:0] r_s1_p1;
    logic [PD_W-1:0]      r_s1_pd;
    logic [CHAN_W-1:0]    r_s1_chan;
    // Stage 2: low sum.
    logic                 r_s2_valid;
    logic [SUM_W-1:0]     r_s2_lo;
    logic [FRAC_BITS-1:0] r_s2_p1;
    logic [CHAN_W-1:0]    r_s2_chan;
    // Stage 3: absolute time, waiting to be emitted.
    logic                 r_s3_valid;
    logic [OFF_W-1:0]     r_s3_t;
    logic [CHAN_W-1:0]    r_s3_chan;

    logic [OFF_W-1:0]     r_out_off;
    logic                 r_o_valid;
    logic                 r_o_special;
    logic [CHAN_W-1:0]    r_o_chan;
    logic [TAG_W-1:0]     r_o_tag;
    logic                 r_o_last;

    logic [PLO_W-1:0]     w_p0;
    logic [PHI_W-1:0]     w_p1;
    logic [PD_W-1:0]      w_pd;
    logic [SUM_W-1:0]     w_full;
    logic [OFF_W-1:0]     w_delta;
    logic [WRAPS_W-1:0]   w_wraps;
    logic                 w_ovf;
    logic                 w_out_ready;
    logic                 w_emit;
    logic                 w_adv;
    logic [OFF_W-1:0]     n_out_off;

    assign w_p0 = PLO_W'(i_head.stamp) * PLO_W'(r_sync_scale[SYNC_LO_W-1:0]);
    assign w_p1 = PHI_W'(i_head.stamp) * PHI_W'(r_sync_scale[SYNC_SCALE_W-1:SYNC_LO_W]);
    assign w_pd = PD_W'(i_head.delay) * PD_W'(r_delay_scale);

    assign w_full = r_s2_lo + {r_s2_p1, OFF_W'(0)};

    // A time far past the output offset first sends an overflow record; the
    // offset then moves up and the same photon is looked at again next cycle.
    assign w_delta     = r_s3_t - r_out_off;
    assign w_wraps     = w_delta[OFF_W-1:TAG_W];
    assign w_ovf       = (w_wraps != '0);
    assign w_out_ready = !r_o_valid || !i_stall;
    assign w_emit      = r_s3_valid && w_out_ready;
    assign w_adv       = !r_s3_valid || (w_emit && !w_ovf);
    assign n_out_off   = r_out_off + {w_wraps, TAG_W'(0)};

    assign o_pop         = w_adv && !i_empty;
    assign o_valid       = r_o_valid;
    assign o_out_special = r_o_special;
    assign o_out_chan    = r_o_chan;
    assign o_time_tag    = r_o_tag;
    assign o_last_of_run = r_o_last;

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_p0   <= w_p0;
            r_s1_p1   <= w_p1[FRAC_BITS-1:0];
            r_s1_pd   <= w_pd;
            r_s1_chan <= i_head.chan;
            r_s2_lo   <= SUM_W'(r_s1_p0) + SUM_W'(r_s1_pd);
            r_s2_p1   <= r_s1_p1;
            r_s2_chan <= r_s1_chan;
            r_s3_t    <= w_full[SUM_W-1:FRAC_BITS];
            r_s3_chan <= r_s2_chan;
        end
        if (w_emit) begin
            if (w_ovf) begin
                r_o_special <= 1'b1;
                r_o_chan    <= OVF_CHAN;
                r_o_tag     <= TAG_W'(w_wraps);
                r_o_last    <= 1'b0;
            end else begin
                r_o_special <= 1'b0;
                r_o_chan    <= r_s3_chan;
                r_o_tag     <= w_delta[TAG_W-1:0];
                r_o_last    <= 1'b1;
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_scale  <= SYNC_SCALE_RST;
            r_delay_scale <= DELAY_SCALE_RST;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_s3_valid    <= 1'b0;
            r_out_off     <= '0;
            r_o_valid     <= 1'b0;
        end else begin
            if (w_adv) begin
                r_s1_valid <= !i_empty;
                r_s2_valid <= r_s1_valid;
                r_s3_valid <= r_s2_valid;
            end
            if (w_emit) begin
                r_o_valid <= 1'b1;
                if (w_ovf) begin
                    r_out_off <= n_out_off;
                end
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (i_cfg.we) begin
                unique case (i_cfg.idx)
                    CFG_SYNC_SCALE:  r_sync_scale  <= i_cfg.data[SYNC_SCALE_W-1:0];
                    CFG_DELAY_SCALE: r_delay_scale <= i_cfg.data[DELAY_SCALE_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

`default_nettype wire

### src/tttr_t3_to_t2_gated_converter.sv
// Top level of the T3 to T2 gated record converter.
// Takes one T3 record per cycle while o_stall is low and turns gated photons
// into T2 records; an overflow record is put out ahead of a photon whenever
// the time since the output offset reaches 2^25. Markers, other special
// records and photons outside the delay gate give no output. The sustained
// rate is one record per cycle while i_stall is low; a photon that needs a T2
// overflow record holds the output stage while that record goes out. A
// photon passes through the queue and then the multiply and add pipeline
// before it reaches the output. A queue of QUEUE_DEPTH entries lets the input
// keep flowing while the output is stalled, until it fills. Configuration must be
// written only while the block holds no work.
`default_nettype none

module tttr_t3_to_t2_gated_converter #(
    parameter int FRAC_BITS   = t3t2_pkg::DEF_FRAC_BITS,
    parameter int QUEUE_DEPTH = t3t2_pkg::DEF_QUEUE_DEPTH
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_we,
    input  wire logic [t3t2_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [t3t2_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  wire logic                              i_valid,
    output logic                                   o_stall,
    input  wire logic [t3t2_pkg::SYNC_W-1:0]       i_sync_count,
    input  wire logic [t3t2_pkg::BIN_W-1:0]        i_delay_bin,
    input  wire logic [t3t2_pkg::CHAN_W-1:0]       i_chan,
    input  wire logic                              i_is_special,
    output logic                                   o_valid,
    input  wire logic                              i_stall,
    output logic                                   o_out_special,
    output logic [t3t2_pkg::CHAN_W-1:0]            o_out_chan,
    output logic [t3t2_pkg::TAG_W-1:0]             o_time_tag,
    output logic                                   o_last_of_run
);
    import t3t2_pkg::*;

    t_cfg_wr w_cfg;
    logic    w_push;
    t_job    w_job;
    logic    w_pop;
    logic    w_full;
    logic    w_empty;
    t_job    w_head;

    assign w_cfg.we   = i_cfg_we;
    assign w_cfg.idx  = t_cfg_idx'(i_cfg_idx);
    assign w_cfg.data = i_cfg_data;
    assign o_stall    = w_full;

    t3t2_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (w_cfg),
        .i_valid      (i_valid),
        .i_sync_count (i_sync_count),
        .i_delay_bin  (i_delay_bin),
        .i_chan       (i_chan),
        .i_is_special (i_is_special),
        .i_full       (w_full),
        .o_push       (w_push),
        .o_job        (w_job)
    );

    t3t2_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    t3t2_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_empty       (w_empty),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_special (o_out_special),
        .o_out_chan    (o_out_chan),
        .o_time_tag    (o_time_tag),
        .o_last_of_run (o_last_of_run)
    );

endmodule

`default_nettype wire

### src/t3t2_checker.sv
// Port-level checks on the T3 to T2 gated record converter, bound to its top level.
`default_nettype none

module t3t2_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic                              o_stall,
    input  wire logic [t3t2_pkg::SYNC_W-1:0]       i_sync_count,
    input  wire logic [t3t2_pkg::BIN_W-1:0]        i_delay_bin,
    input  wire logic [t3t2_pkg::CHAN_W-1:0]       i_chan,
    input  wire logic                              i_is_special,
    input  wire logic                              o_valid,
    input  wire logic                              i_stall,
    input  wire logic                              o_out_special,
    input  wire logic [t3t2_pkg::CHAN_W-1:0]       o_out_chan,
    input  wire logic [t3t2_pkg::TAG_W-1:0]        o_time_tag,
    input  wire logic                              o_last_of_run
);
    import t3t2_pkg::*;

    // Nothing comes out in the cycle after reset.
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output beat shown right after reset");

    // An overflow beat always carries the overflow channel, a non-zero
    // wrap count, and is never the last beat of its record.
    a_ovf_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_out_special) |->
            (o_out_chan == OVF_CHAN) && (o_time_tag != '0) && !o_last_of_run)
        else $error("malformed overflow beat");

    // Each photon beat closes the run of its record.
    a_photon_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_out_special) |-> o_last_of_run)
        else $error("photon beat without last flag");

    // A stalled output beat stays and keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            o_valid && $stable(o_out_special) && $stable(o_out_chan)
            && $stable(o_time_tag) && $stable(o_last_of_run))
        else $error("stalled output beat changed");

    // A stalled input beat stays offered and keeps its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_stall) |=>
            i_valid && $stable(i_sync_count) && $stable(i_delay_bin)
            && $stable(i_chan) && $stable(i_is_special))
        else $error("stalled input beat changed");

endmodule

bind tttr_t3_to_t2_gated_converter t3t2_checker u_t3t2_checker (.*);

`default_nettype wire

### tb/sv/tttr_t3_to_t2_gated_converter_tb.sv
// Self-checking testbench for the T3 to T2 gated record converter.
module tttr_t3_to_t2_gated_converter_tb ();
    timeunit 1ns;
    timeprecision 1ps;
    import t3t2_pkg::*;

    localparam int FRAC            = DEF_FRAC_BITS;
    localparam int DRAIN_CYCLES    = 16;
    localparam int HOLDOFF_CYCLES  = 300;
    localparam int WATCHDOG_CYCLES = 4000;
    localparam int MAX_REPORTS     = 10;
    localparam int PHASE_RECORDS   = 155;
    localparam int OVF_RUN_RECORDS = 300;

    typedef struct packed {
        logic              special;
        logic [CHAN_W-1:0] chan;
        logic [TAG_W-1:0]  tag;
        logic              last;
    } t2_rec_t;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_cfg_we     = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx    = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data   = '0;
    logic                  i_valid      = 1'b0;
    logic [SYNC_W-1:0]     i_sync_count = '0;
    logic [BIN_W-1:0]      i_delay_bin  = '0;
    logic [CHAN_W-1:0]     i_chan       = '0;
    logic                  i_is_special = 1'b0;
    logic                  i_stall      = 1'b0;
    logic                  o_stall;
    logic                  o_valid;
    logic                  o_out_special;
    logic [CHAN_W-1:0]     o_out_chan;
    logic [TAG_W-1:0]      o_time_tag;
    logic                  o_last_of_run;

    // Shadow copy of the registers and the two wrap offsets.
    logic [SYNC_SCALE_W-1:0]  sync_scale_q  = SYNC_SCALE_RST;
    logic [DELAY_SCALE_W-1:0] delay_scale_q = DELAY_SCALE_RST;
    logic [BIN_W-1:0]         gate_lo_q     = GATE_LOW_RST;
    logic [BIN_W-1:0]         gate_hi_q     = GATE_HIGH_RST;
    logic [OFF_W-1:0]         t3_wrap_base  = '0;
    logic [OFF_W-1:0]         t2_wrap_base  = '0;

    t2_rec_t t2_expected_q[$];

    bit tx_gaps = 1'b0;
    bit rx_gaps = 1'b0;
    int holdoff_requests = 0;
    int holdoff_served   = 0;
    int holdoff_left     = 0;

    int mismatches     = 0;
    int photons_in     = 0;
    int overflows_in   = 0;
    int others_in      = 0;
    int t2_checked     = 0;
    int t2_overflows   = 0;
    int cfg_writes     = 0;
    int stalled_cycles = 0;
    int quiet_cycles   = 0;

    always #6 i_clk = ~i_clk;

    tttr_t3_to_t2_gated_converter #(
        .FRAC_BITS (FRAC)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_sync_count  (i_sync_count),
        .i_delay_bin   (i_delay_bin),
        .i_chan        (i_chan),
        .i_is_special  (i_is_special),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_special (o_out_special),
        .o_out_chan    (o_out_chan),
        .o_time_tag    (o_time_tag),
        .o_last_of_run (o_last_of_run)
    );

    // Works out the T2 records that one accepted T3 record should produce.
    task automatic predict_t2_records(input logic [SYNC_W-1:0] sync,
                                      input logic [BIN_W-1:0] delay,
                                      input logic [CHAN_W-1:0] chan,
                                      input logic special);
        logic [OFF_W-1:0] stamp;
        logic [OFF_W-1:0] t_abs;
        logic [OFF_W-1:0] span;
        logic [80:0]      acc;
        t2_rec_t          rec;
        if (special) begin
            if (chan == OVF_CHAN) begin
                t3_wrap_base = t3_wrap_base + (OFF_W'(sync) << T3_WRAP_BITS);
            end
        end else if (delay >= gate_lo_q && delay <= gate_hi_q) begin
            stamp = t3_wrap_base + OFF_W'(sync);
            acc   = 81'(stamp) * 81'(sync_scale_q) + 81'(delay) * 81'(delay_scale_q);
            t_abs = acc[FRAC +: OFF_W];
            span  = t_abs - t2_wrap_base;
            if (span[OFF_W-1:TAG_W] != '0) begin
                t2_wrap_base = t2_wrap_base + {span[OFF_W-1:TAG_W], {TAG_W{1'b0}}};
                rec.special  = 1'b1;
                rec.chan     = OVF_CHAN;
                rec.tag      = TAG_W'(span[OFF_W-1:TAG_W]);
                rec.last     = 1'b0;
                t2_expected_q.push_back(rec);
            end
            rec.special = 1'b0;
            rec.chan    = chan;
            rec.tag     = span[TAG_W-1:0];
            rec.last    = 1'b1;
            t2_expected_q.push_back(rec);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            predict_t2_records(i_sync_count, i_delay_bin, i_chan, i_is_special);
            if (!i_is_special) begin
                photons_in++;
            end else if (i_chan == OVF_CHAN) begin
                overflows_in++;
            end else begin
                others_in++;
            end
        end
    end

    always @(posedge i_clk) begin : t2_check
        t2_rec_t got;
        t2_rec_t want;
        if (i_rst_n && o_valid && !i_stall) begin
            got.special = o_out_special;
            got.chan    = o_out_chan;
            got.tag     = o_time_tag;
            got.last    = o_last_of_run;
            t2_checked++;
            if (got.special) begin
                t2_overflows++;
            end
            if (t2_expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("Unexpected T2 beat: special=%0d chan=%0d tag=%0d last=%0d",
                             got.special, got.chan, got.tag, got.last);
                end
            end else begin
                want = t2_expected_q.pop_front();
                if (got != want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("T2 beat %0d: expected special=%0d chan=%0d tag=%0d last=%0d",
                                 t2_checked, want.special, want.chan, want.tag, want.last);
                        $display("            got      special=%0d chan=%0d tag=%0d last=%0d",
                                 got.special, got.chan, got.tag, got.last);
                    end
                end
            end
        end
    end

    // Receiver: random stalls, or a long hold-off when the test asks for one.
    always @(posedge i_clk) begin
        if (holdoff_requests != holdoff_served) begin
            holdoff_served <= holdoff_requests;
            holdoff_left   <= HOLDOFF_CYCLES - 1;
            i_stall        <= 1'b1;
        end else if (holdoff_left != 0) begin
            holdoff_left <= holdoff_left - 1;
            i_stall      <= 1'b1;
        end else begin
            i_stall <= rx_gaps && ($urandom_range(99) < 35);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (i_valid && o_stall) begin
            stalled_cycles <= stalled_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_CYCLES) begin
            $display("Timeout: no beat for %0d cycles, %0d T2 records outstanding",
                     WATCHDOG_CYCLES, t2_expected_q.size());
            $display("tttr_t3_to_t2_gated_converter test failed");
            $finish;
        end
    end

    task automatic send_t3(input logic [SYNC_W-1:0] sync, input logic [BIN_W-1:0] delay,
                           input logic [CHAN_W-1:0] chan, input logic special);
        while (tx_gaps && $urandom_range(99) < 35) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_sync_count <= sync;
        i_delay_bin  <= delay;
        i_chan       <= chan;
        i_is_special <= special;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    // Lets every expected record come out, then gives gated-out photons time to clear.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (t2_expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_SYNC_SCALE:  sync_scale_q  = data[SYNC_SCALE_W-1:0];
            CFG_DELAY_SCALE: delay_scale_q = data[DELAY_SCALE_W-1:0];
            CFG_GATE_LOW:    gate_lo_q     = data[BIN_W-1:0];
            CFG_GATE_HIGH:   gate_hi_q     = data[BIN_W-1:0];
            default: ;
        endcase
        cfg_writes++;
        @(posedge i_clk);
    endtask

    function automatic logic [SYNC_SCALE_W-1:0] rand_scale();
        logic [SYNC_SCALE_W-1:0] v;
        v = {16'($urandom), 32'($urandom)};
        return v >> $urandom_range(SYNC_SCALE_W - 1);
    endfunction

    // Photon inside the gate, with random content.
    task automatic send_gated_photon();
        logic [BIN_W-1:0] delay;
        delay = BIN_W'($urandom_range(int'(gate_hi_q), int'(gate_lo_q)));
        send_t3(SYNC_W'($urandom), delay, CHAN_W'($urandom), 1'b0);
    endtask

    task automatic send_random_t3();
        int r;
        r = $urandom_range(99);
        if (r < 45 && gate_lo_q <= gate_hi_q) begin
            send_gated_photon();
        end else if (r < 72) begin
            send_t3(SYNC_W'($urandom), BIN_W'($urandom), CHAN_W'($urandom), 1'b0);
        end else if (r < 86) begin
            send_t3(SYNC_W'($urandom), BIN_W'($urandom), OVF_CHAN, 1'b1);
        end else begin
            send_t3(SYNC_W'($urandom), BIN_W'($urandom),
                    CHAN_W'($urandom_range(int'(OVF_CHAN) - 1)), 1'b1);
        end
    endtask

    // Reset values, markers and other special records, overflow records,
    // and a photon on the overflow channel number.
    task automatic test_defaults_and_specials();
        send_t3(10'd0, 15'd0, 6'd0, 1'b0);
        send_t3(10'd1023, 15'd32767, OVF_CHAN, 1'b0);
        send_t3(10'd5, 15'd7, 6'd1, 1'b1);
        send_t3(10'd5, 15'd7, 6'd15, 1'b1);
        send_t3(10'd5, 15'd7, 6'd0, 1'b1);
        send_t3(10'd5, 15'd7, 6'd62, 1'b1);
        send_t3(10'd0, 15'd0, OVF_CHAN, 1'b1);
        send_t3(10'd1023, 15'd32767, OVF_CHAN, 1'b1);
        send_t3(10'd512, 15'd1, 6'd42, 1'b0);
        drain();
    endtask

    // Both gate edges, an empty gate, a gate one bin wide, then the full gate
    // written with junk in the bits above the register.
    task automatic test_gate_edges();
        write_cfg(CFG_GATE_LOW, 48'd100);
        write_cfg(CFG_GATE_HIGH, 48'd200);
        send_t3(10'd3, 15'd99, 6'd3, 1'b0);
        send_t3(10'd3, 15'd100, 6'd3, 1'b0);
        send_t3(10'd3, 15'd200, 6'd3, 1'b0);
        send_t3(10'd3, 15'd201, 6'd3, 1'b0);
        drain();
        write_cfg(CFG_GATE_LOW, 48'd300);
        send_t3(10'd4, 15'd250, 6'd4, 1'b0);
        send_t3(10'd4, 15'd300, 6'd4, 1'b0);
        drain();
        write_cfg(CFG_GATE_LOW, 48'd0);
        write_cfg(CFG_GATE_HIGH, 48'd0);
        send_t3(10'd6, 15'd0, 6'd6, 1'b0);
        send_t3(10'd6, 15'd1, 6'd6, 1'b0);
        drain();
        write_cfg(CFG_GATE_LOW, 48'hFFFF_FFFF_8000);
        write_cfg(CFG_GATE_HIGH, 48'hFFFF_FFFF_FFFF);
    endtask

    // Largest and zero scales, so the output offset is forced to wrap.
    task automatic test_scale_extremes();
        write_cfg(CFG_SYNC_SCALE, 48'hFFFF_FFFF_FFFF);
        write_cfg(CFG_DELAY_SCALE, 48'h0000_FFFF_FFFF);
        send_t3(10'd1023, 15'd32767, 6'd21, 1'b0);
        send_t3(10'd0, 15'd0, 6'd5, 1'b0);
        send_t3(10'd1, 15'd1, 6'd10, 1'b0);
        send_t3(10'd1023, 15'd0, OVF_CHAN, 1'b1);
        send_t3(10'd700, 15'd12345, 6'd33, 1'b0);
        drain();
        write_cfg(CFG_SYNC_SCALE, 48'd0);
        write_cfg(CFG_DELAY_SCALE, 48'hFFFF_0000_0000);
        send_t3(10'd1023, 15'd32767, 6'd9, 1'b0);
        drain();
        write_cfg(CFG_SYNC_SCALE, SYNC_SCALE_RST);
        write_cfg(CFG_DELAY_SCALE, 48'(DELAY_SCALE_RST));
    endtask

    // A long run of full overflow records that carries the input offset far up,
    // with photons mixed in along the way.
    task automatic test_input_offset_wrap();
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        for (int n = 0; n < OVF_RUN_RECORDS; n++) begin
            send_t3(10'd1023, BIN_W'($urandom), OVF_CHAN, 1'b1);
            if (n % 32 == 0 || n == OVF_RUN_RECORDS - 1) begin
                send_gated_photon();
            end
        end
        drain();
    endtask

    // The receiver holds off while beats keep coming, so the queue fills up.
    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        holdoff_requests++;
        repeat (40) send_gated_photon();
        drain();
    endtask

    task automatic test_random_configs();
        logic [BIN_W-1:0] lo;
        logic [BIN_W-1:0] hi;
        for (int p = 0; p < 5; p++) begin
            lo = BIN_W'($urandom_range(32767));
            hi = BIN_W'($urandom_range(32767, int'(lo)));
            tx_gaps = (p != 0);
            rx_gaps = (p != 0);
            case (p)
                0: begin
                    write_cfg(CFG_SYNC_SCALE, SYNC_SCALE_RST);
                    write_cfg(CFG_DELAY_SCALE, 48'(DELAY_SCALE_RST));
                    lo = '0;
                    hi = '1;
                end
                1: begin
                    write_cfg(CFG_SYNC_SCALE, 48'hFFFF_FFFF_FFFF);
                    write_cfg(CFG_DELAY_SCALE, 48'h0000_FFFF_FFFF);
                    lo = '0;
                    hi = '1;
                end
                3: begin
                    write_cfg(CFG_SYNC_SCALE, 48'd0);
                    write_cfg(CFG_DELAY_SCALE, 48'd0);
                end
                4: begin
                    write_cfg(CFG_SYNC_SCALE, rand_scale());
                    write_cfg(CFG_DELAY_SCALE, {16'($urandom), 32'(rand_scale())});
                    // Either order, so the gate may well be empty here.
                    hi = BIN_W'($urandom);
                end
                default: begin
                    write_cfg(CFG_SYNC_SCALE, rand_scale());
                    write_cfg(CFG_DELAY_SCALE, {16'($urandom), 32'(rand_scale())});
                end
            endcase
            write_cfg(CFG_GATE_LOW, {33'({$urandom, $urandom}), lo});
            write_cfg(CFG_GATE_HIGH, {33'({$urandom, $urandom}), hi});
            repeat (PHASE_RECORDS) send_random_t3();
            drain();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults_and_specials();
        test_gate_edges();
        test_scale_extremes();
        test_input_offset_wrap();
        test_backpressure();
        test_random_configs();
        $display("Sent %0d photons, %0d T3 overflows and %0d other special records; %0d writes",
                 photons_in, overflows_in, others_in, cfg_writes);
        $display("Checked %0d T2 records (%0d overflow), input stalled for %0d cycles",
                 t2_checked, t2_overflows, stalled_cycles);
        if (mismatches == 0 && t2_expected_q.size() == 0) begin
            $display("tttr_t3_to_t2_gated_converter test passed");
        end else begin
            $display("tttr_t3_to_t2_gated_converter test failed");
        end
        $finish;
    end

endmodule
